// ===== rtl/rkl_pkg.sv =====
package rkl_pkg;

    localparam int AGENT_COUNT = 16;
    localparam int AGENT_W     = $clog2(AGENT_COUNT);
    localparam int CH_COUNT    = 3;
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CH_FOLLOWER = 2'd0;
    localparam logic [1:0] CH_LEADER   = 2'd1;
    localparam logic [1:0] CH_BASE     = 2'd2;

    localparam logic [1:0] KIND_PEER  = 2'd0;
    localparam logic [1:0] KIND_BASE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [2:0] CFG_FOLLOWER_ID    = 3'd0;
    localparam logic [2:0] CFG_LEADER_ID      = 3'd1;
    localparam logic [2:0] CFG_NOISE_Q        = 3'd2;
    localparam logic [2:0] CFG_NOISE_R        = 3'd3;
    localparam logic [2:0] CFG_SPEED_GAIN     = 3'd4;
    localparam logic [2:0] CFG_DANGER_LEVEL   = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT_TICKS  = 3'd6;
    localparam logic [2:0] CFG_COOLDOWN_TICKS = 3'd7;

    localparam signed [24:0] EST_MAX = 25'sh0FFFFFF;
    localparam signed [24:0] EST_MIN = -25'sh1000000;
    localparam logic [23:0]  COV_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FILT,
        OP_RAW,
        OP_QFILT,
        OP_QRAW
    } op_t;

    typedef struct packed {
        logic [3:0]          follower_id;
        logic [3:0]          leader_id;
        logic [23:0]         noise_q;
        logic [23:0]         noise_r;
        logic signed [15:0]  speed_gain;
        logic [7:0]          danger_level;
        logic [31:0]         timeout_ticks;
        logic [15:0]         cooldown_ticks;
    } cfg_t;

    typedef struct packed {
        op_t                 op;
        logic [1:0]          ch;
        logic [3:0]          agent_id;
        logic [7:0]          sample;
        logic signed [15:0]  speed;
        logic [31:0]         now;
    } item_t;

    function automatic logic signed [24:0] sat25(input logic signed [45:0] x);
        logic signed [24:0] r;
        if (x > 46'(EST_MAX))
            r = EST_MAX;
        else if (x < 46'(EST_MIN))
            r = EST_MIN;
        else
            r = x[24:0];
        return r;
    endfunction

endpackage

// ===== rtl/rkl_req_if.sv =====
interface rkl_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [3:0]         agent_id;
    logic [7:0]         sample;
    logic signed [15:0] speed;
    logic [31:0]        now;

    modport source (output valid, kind, agent_id, sample, speed, now, input ready);
    modport sink (input valid, kind, agent_id, sample, speed, now, output ready);
endinterface

// ===== rtl/rkl_rsp_if.sv =====
interface rkl_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] estimate;
    logic               updated;
    logic               connected;

    modport source (output valid, estimate, updated, connected, input ready);
    modport sink (input valid, estimate, updated, connected, output ready);
endinterface

// ===== rtl/rkl_front.sv =====
module rkl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  rkl_pkg::cfg_t   cfg,
    rkl_req_if.sink         req,
    output logic            q_valid,
    output rkl_pkg::item_t  q_item,
    input  logic            q_pop
);

    rkl_pkg::item_t slot_reg [rkl_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    rkl_pkg::item_t cls;
    logic           push;
    logic           has_ch;
    logic [1:0]     ch;
    logic           in_range;

    always_comb
    begin
        has_ch   = 1'b1;
        ch       = rkl_pkg::CH_FOLLOWER;
        if (req.agent_id == cfg.follower_id)
            ch = rkl_pkg::CH_FOLLOWER;
        else if (req.agent_id == cfg.leader_id)
            ch = rkl_pkg::CH_LEADER;
        else
            has_ch = 1'b0;
        in_range = (int'(req.agent_id) < rkl_pkg::AGENT_COUNT);

        cls.ch       = ch;
        cls.agent_id = req.agent_id;
        cls.sample   = req.sample;
        cls.speed    = req.speed;
        cls.now      = req.now;
        cls.op       = rkl_pkg::OP_NONE;
        unique case (req.kind)
            rkl_pkg::KIND_PEER:
            begin
                if (has_ch)
                    cls.op = rkl_pkg::OP_FILT;
                else if (in_range)
                    cls.op = rkl_pkg::OP_RAW;
            end
            rkl_pkg::KIND_BASE:
            begin
                cls.op = rkl_pkg::OP_FILT;
                cls.ch = rkl_pkg::CH_BASE;
            end
            rkl_pkg::KIND_QUERY:
            begin
                if (has_ch)
                    cls.op = rkl_pkg::OP_QFILT;
                else if (in_range)
                    cls.op = rkl_pkg::OP_QRAW;
            end
            default:
                cls.op = rkl_pkg::OP_NONE;
        endcase
    end

    assign req.ready = (count_reg != 2'(rkl_pkg::QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ===== rtl/rkl_back.sv =====
module rkl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  rkl_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  rkl_pkg::item_t  q_item,
    output logic            q_pop,
    rkl_rsp_if.source       rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PRED,
        S_DIV,
        S_MUL,
        S_FIN,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    rkl_pkg::item_t         item_reg, item_next;
    logic signed [24:0]     fe_reg [rkl_pkg::CH_COUNT];
    logic signed [24:0]     fe_next [rkl_pkg::CH_COUNT];
    logic [23:0]            fc_reg [rkl_pkg::CH_COUNT];
    logic [23:0]            fc_next [rkl_pkg::CH_COUNT];
    logic [31:0]            ft_reg [rkl_pkg::CH_COUNT];
    logic [31:0]            ft_next [rkl_pkg::CH_COUNT];
    logic [7:0]             rl_reg [rkl_pkg::AGENT_COUNT];
    logic [7:0]             rl_next [rkl_pkg::AGENT_COUNT];
    logic [31:0]            rt_reg [rkl_pkg::AGENT_COUNT];
    logic [31:0]            rt_next [rkl_pkg::AGENT_COUNT];

    logic signed [31:0]     prod_reg, prod_next;
    logic [23:0]            pp_reg, pp_next;
    logic signed [24:0]     ep_reg, ep_next;
    logic [24:0]            den_reg, den_next;
    logic [25:0]            rem_reg, rem_next;
    logic [16:0]            quo_reg, quo_next;
    logic [rkl_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [26:0]     diff_reg, diff_next;
    logic signed [44:0]     kd_reg, kd_next;
    logic [40:0]            kp_reg, kp_next;

    logic                   valid_reg, valid_next;
    logic signed [24:0]     est_reg, est_next;
    logic                   upd_reg, upd_next;
    logic                   conn_reg, conn_next;

    logic signed [24:0]     e_cur;
    logic [31:0]            dt_filt;
    logic [31:0]            dt_raw;
    logic [rkl_pkg::AGENT_W-1:0] aidx;
    logic [7:0]             lv;
    logic [24:0]            pp_sum;
    logic signed [32:0]     rnd4;
    logic signed [29:0]     ep_sum;
    logic [16:0]            k;
    logic signed [45:0]     kd_rnd;
    logic [41:0]            kp_rnd;
    logic signed [26:0]     p_new;
    logic signed [24:0]     seed;

    assign aidx  = item_reg.agent_id[rkl_pkg::AGENT_W-1:0];
    assign e_cur = fe_reg[item_reg.ch];
    assign lv    = rl_reg[aidx];
    assign dt_filt = item_reg.now - ft_reg[item_reg.ch];
    assign dt_raw  = item_reg.now - rt_reg[aidx];
    assign seed    = $signed({1'b0, item_reg.sample, 16'h0000});
    assign pp_sum  = {1'b0, fc_reg[item_reg.ch]} + {1'b0, cfg.noise_r};
    assign rnd4    = 33'(prod_reg) + 33'sd8;
    assign ep_sum  = 30'(e_cur) + 30'($signed(rnd4[32:4]));
    assign k       = (den_reg == 25'd0) ? 17'd0 : quo_reg;
    assign kd_rnd  = 46'(kd_reg) + 46'sd32768;
    assign kp_rnd  = {1'b0, kp_reg} + 42'd32768;
    assign p_new   = $signed({3'b000, pp_reg}) - $signed({1'b0, kp_rnd[41:16]});

    assign q_pop         = (state_reg == S_IDLE) && q_valid;
    assign rsp.valid     = valid_reg;
    assign rsp.estimate  = est_reg;
    assign rsp.updated   = upd_reg;
    assign rsp.connected = conn_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        fe_next    = fe_reg;
        fc_next    = fc_reg;
        ft_next    = ft_reg;
        rl_next    = rl_reg;
        rt_next    = rt_reg;
        prod_next  = prod_reg;
        pp_next    = pp_reg;
        ep_next    = ep_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        diff_next  = diff_reg;
        kd_next    = kd_reg;
        kp_next    = kp_reg;
        valid_next = valid_reg;
        est_next   = est_reg;
        upd_next   = upd_reg;
        conn_next  = conn_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                est_next   = '0;
                upd_next   = 1'b0;
                conn_next  = 1'b0;
                state_next = S_OUT;
                unique case (item_reg.op)
                    rkl_pkg::OP_RAW:
                    begin
                        rl_next[aidx] = item_reg.sample;
                        rt_next[aidx] = item_reg.now;
                        upd_next      = 1'b1;
                        est_next      = seed;
                    end
                    rkl_pkg::OP_QRAW:
                    begin
                        est_next  = $signed({1'b0, lv, 16'h0000});
                        conn_next = (lv != 8'd0) && (lv < cfg.danger_level)
                                    && (dt_raw < cfg.timeout_ticks);
                    end
                    rkl_pkg::OP_QFILT:
                    begin
                        est_next  = e_cur;
                        conn_next = (e_cur > 25'sd0)
                                    && (e_cur < $signed({1'b0, cfg.danger_level, 16'h0000}))
                                    && (dt_filt < cfg.timeout_ticks);
                    end
                    rkl_pkg::OP_FILT:
                    begin
                        if (e_cur == 25'sd0)
                        begin
                            fe_next[item_reg.ch] = seed;
                            fc_next[item_reg.ch] = cfg.noise_q;
                            ft_next[item_reg.ch] = item_reg.now;
                            est_next = seed;
                            upd_next = 1'b1;
                        end
                        else if (dt_filt > 32'(cfg.cooldown_ticks))
                        begin
                            prod_next  = cfg.speed_gain * item_reg.speed;
                            pp_next    = pp_sum[24] ? rkl_pkg::COV_MAX : pp_sum[23:0];
                            state_next = S_PRED;
                        end
                        else
                        begin
                            est_next = e_cur;
                        end
                    end
                    default:
                    begin
                        est_next = '0;
                    end
                endcase
            end
            S_PRED:
            begin
                ep_next    = rkl_pkg::sat25(46'(ep_sum));
                den_next   = {1'b0, pp_reg} + {1'b0, cfg.noise_q};
                rem_next   = {2'b00, pp_reg};
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                diff_next = $signed({3'b000, item_reg.sample, 16'h0000}) - 27'(ep_reg);
                if (rem_reg >= {1'b0, den_reg})
                begin
                    rem_next = {rem_reg[24:0] - den_reg, 1'b0};
                    quo_next = {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[24:0], 1'b0};
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == rkl_pkg::DIV_CNT_W'(rkl_pkg::DIV_STEPS - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                kd_next    = $signed({1'b0, k}) * diff_reg;
                kp_next    = k * pp_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                est_next = rkl_pkg::sat25(46'(ep_reg) + 46'($signed(kd_rnd[45:16])));
                fe_next[item_reg.ch] = est_next;
                fc_next[item_reg.ch] = p_new[26] ? 24'd0 : p_new[23:0];
                ft_next[item_reg.ch] = item_reg.now;
                upd_next   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        valid_next = (state_next == S_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            est_reg   <= '0;
            upd_reg   <= 1'b0;
            conn_reg  <= 1'b0;
            for (int i = 0; i < rkl_pkg::CH_COUNT; i++)
            begin
                fe_reg[i] <= '0;
                fc_reg[i] <= '0;
                ft_reg[i] <= '0;
            end
            for (int i = 0; i < rkl_pkg::AGENT_COUNT; i++)
            begin
                rl_reg[i] <= '0;
                rt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            est_reg   <= est_next;
            upd_reg   <= upd_next;
            conn_reg  <= conn_next;
            fe_reg    <= fe_next;
            fc_reg    <= fc_next;
            ft_reg    <= ft_next;
            rl_reg    <= rl_next;
            rt_reg    <= rt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prod_reg <= prod_next;
        pp_reg   <= pp_next;
        ep_reg   <= ep_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        diff_reg <= diff_next;
        kd_reg   <= kd_next;
        kp_reg   <= kp_next;
    end

endmodule

// ===== rtl/rssi_kalman_link_tracker.sv =====
// RSSI link tracker with scalar Kalman filters for follower, leader and base.
// req channel: valid/ready; one transfer carries kind, agent_id, sample,
//   speed and now. rsp channel: valid/ready; exactly one result transfer per
//   request, in order, with estimate, updated and connected.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the
//   clock edge; write only while no request is in flight.
// Flow: a request is written into the two-entry input queue, then the
//   filter engine pops it and decodes it. Raw stores, queries, seeds and
//   cooldown skips go straight from decode to the output state; a full
//   Kalman update first runs prediction, the 17-step restoring divider for
//   the gain, a multiply state (S_MUL) and a final update state (S_FIN).
// Queueing: the engine works on one request at a time and pops another
//   only after its result is taken; the queue keeps accepting while the
//   engine works, up to two waiting requests.
// Stall: a result holds on rsp until taken; the engine then waits, and
//   req.ready drops once the queue is full.
// Reset: all filter and raw state clears to zero (no data) and the
//   registers take their defaults; both channels come up empty.
module rssi_kalman_link_tracker (
    input  logic        clk,
    input  logic        rst_n,
    rkl_req_if.sink     req,
    rkl_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    rkl_pkg::cfg_t  cfg_reg, cfg_next;
    logic           q_valid;
    logic           q_pop;
    rkl_pkg::item_t q_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rkl_pkg::CFG_FOLLOWER_ID:    cfg_next.follower_id    = cfg_wdata[3:0];
                rkl_pkg::CFG_LEADER_ID:      cfg_next.leader_id      = cfg_wdata[3:0];
                rkl_pkg::CFG_NOISE_Q:        cfg_next.noise_q        = cfg_wdata[23:0];
                rkl_pkg::CFG_NOISE_R:        cfg_next.noise_r        = cfg_wdata[23:0];
                rkl_pkg::CFG_SPEED_GAIN:     cfg_next.speed_gain     = cfg_wdata[15:0];
                rkl_pkg::CFG_DANGER_LEVEL:   cfg_next.danger_level   = cfg_wdata[7:0];
                rkl_pkg::CFG_TIMEOUT_TICKS:  cfg_next.timeout_ticks  = cfg_wdata;
                rkl_pkg::CFG_COOLDOWN_TICKS: cfg_next.cooldown_ticks = cfg_wdata[15:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.follower_id    <= 4'd1;
            cfg_reg.leader_id      <= 4'd2;
            cfg_reg.noise_q        <= 24'd65536;
            cfg_reg.noise_r        <= 24'd65536;
            cfg_reg.speed_gain     <= 16'sd0;
            cfg_reg.danger_level   <= 8'd80;
            cfg_reg.timeout_ticks  <= 32'd1000;
            cfg_reg.cooldown_ticks <= 16'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rkl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    rkl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
